@@ hdl/bres_pkg.sv @@
// Shared constants, types and normalization tables for the bilinear resize block.
package bres_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int OUT_SIZE   = 224;
    localparam int FRAC_BITS  = 16;

    localparam int DIM_W   = 9;
    localparam int POS_W   = 8;
    localparam int CH_W    = 8;
    localparam int PIX_W   = 3 * CH_W;
    localparam int NORM_W  = 16;
    localparam int BANKS   = 4;
    localparam int BANK_AW = 2 * (POS_W - 1);
    localparam int BANK_DEPTH = (MAX_WIDTH * MAX_HEIGHT) / BANKS;

    // sample numerator (2p+1)*m - N, and its floor(num*2^FRAC_BITS / 2N)
    localparam int NUM_W   = 18;
    localparam int DEN     = 2 * OUT_SIZE;
    localparam int Q_INT   = (1 << FRAC_BITS) / DEN;
    localparam int Q_REM2  = (1 << FRAC_BITS) % DEN;
    localparam int DIV_DEN = 2 * DEN / Q_REM2;
    localparam int RCP_SH  = 22;
    localparam int RCP_MUL = ((1 << RCP_SH) + DIV_DEN - 1) / DIV_DEN;
    localparam int RCP_W   = 20;
    localparam int ACC_W   = 26;
    localparam int LIM_W   = 19;
    localparam int WGT_W   = FRAC_BITS + 1;
    localparam int ROW_W   = CH_W + FRAC_BITS;
    localparam int SUM_W   = ROW_W + WGT_W;

    localparam longint MEAN_R = 123675;
    localparam longint MEAN_G = 116280;
    localparam longint MEAN_B = 103530;
    localparam longint STD_R  = 58395;
    localparam longint STD_G  = 57120;
    localparam longint STD_B  = 57375;

    localparam logic ACT_WRITE   = 1'b0;
    localparam logic ACT_REQUEST = 1'b1;

    localparam logic REG_SRC_WIDTH  = 1'b0;
    localparam logic REG_SRC_HEIGHT = 1'b1;

    typedef logic signed [NORM_W-1:0] norm_lut_t [256];

    function automatic norm_lut_t build_norm_lut(input int ch);
        norm_lut_t t;
        longint    n;
        longint    a;
        longint    q;
        for (int v = 0; v < 256; v++)
        begin
            case (ch)
                0:       n = (longint'(v) * 1000 - MEAN_R) * 4096;
                1:       n = (longint'(v) * 1000 - MEAN_G) * 4096;
                default: n = (longint'(v) * 1000 - MEAN_B) * 4096;
            endcase
            a = (n < 0) ? -n : n;
            case (ch)
                0:       q = (2 * a + STD_R) / (2 * STD_R);
                1:       q = (2 * a + STD_G) / (2 * STD_G);
                default: q = (2 * a + STD_B) / (2 * STD_B);
            endcase
            if (n < 0)
                q = -q;
            if (q > 32767)
                q = 32767;
            if (q < -32768)
                q = -32768;
            t[v] = NORM_W'(q);
        end
        return t;
    endfunction

    localparam norm_lut_t NORM_LUT_R = build_norm_lut(0);
    localparam norm_lut_t NORM_LUT_G = build_norm_lut(1);
    localparam norm_lut_t NORM_LUT_B = build_norm_lut(2);

endpackage

@@ hdl/bres_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bres_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/bilinear_resize_normalize.sv @@
// Bilinear resize and normalize top level: banked source store and resample pipeline.
//
//  channel | signals                                          | transfer when
//  --------+--------------------------------------------------+---------------------
//  request | req_valid req_ready action pos_x pos_y red green blue | req_valid & req_ready
//  result  | res_valid res_ready out_red/green/blue in_range  | res_valid & res_ready
//  config  | cfg_we cfg_index cfg_data                        | cfg_we
//
// One item per clock while res_ready does not stall; a request passes stages 1-6 and the output register.
// Four parity banks of the source store give all four neighbours in one read.
// Each stage advances when it is empty or its successor advances; bubbles collapse.
// Reset clears the valid bits and sets both source dimensions to 224.
module bilinear_resize_normalize
    import bres_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_ready,
    input  logic                     action,
    input  logic [POS_W-1:0]         pos_x,
    input  logic [POS_W-1:0]         pos_y,
    input  logic [CH_W-1:0]          red,
    input  logic [CH_W-1:0]          green,
    input  logic [CH_W-1:0]          blue,
    output logic                     res_valid,
    input  logic                     res_ready,
    output logic signed [NORM_W-1:0] out_red,
    output logic signed [NORM_W-1:0] out_green,
    output logic signed [NORM_W-1:0] out_blue,
    output logic                     in_range,
    input  logic                     cfg_we,
    input  logic                     cfg_index,
    input  logic [DIM_W-1:0]         cfg_data
);

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [DIM_W-1:0] w_c;
    logic [DIM_W-1:0] h_c;
    logic [DIM_W-1:0] m_c;

    logic [6:1] vld_reg;
    logic [6:1] en;
    logic       out_vld_reg;
    logic       en_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(224);
            height_reg <= DIM_W'(224);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SRC_WIDTH:  width_reg  <= cfg_data;
                REG_SRC_HEIGHT: height_reg <= cfg_data;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg == '0)
            w_c = DIM_W'(1);
        else if (width_reg > DIM_W'(MAX_WIDTH))
            w_c = DIM_W'(MAX_WIDTH);
        else
            w_c = width_reg;
        if (height_reg == '0)
            h_c = DIM_W'(1);
        else if (height_reg > DIM_W'(MAX_HEIGHT))
            h_c = DIM_W'(MAX_HEIGHT);
        else
            h_c = height_reg;
        m_c = (w_c > h_c) ? w_c : h_c;
    end

    assign en_out = !out_vld_reg || res_ready;
    assign en[6]  = !vld_reg[6] || en_out;
    assign en[5]  = !vld_reg[5] || en[6];
    assign en[4]  = !vld_reg[4] || en[5];
    assign en[3]  = !vld_reg[3] || en[4];
    assign en[2]  = !vld_reg[2] || en[3];
    assign en[1]  = !vld_reg[1] || en[2];
    assign req_ready = en[1];

    // stage 1: sample numerators and active-area check
    logic [NUM_W-1:0] prod_x;
    logic [NUM_W-1:0] prod_y;
    logic [LIM_W-1:0] lhs_x;
    logic [LIM_W-1:0] lhs_y;
    logic [LIM_W-1:0] lim_w;
    logic [LIM_W-1:0] lim_h;

    logic             act1_reg;
    logic [POS_W-1:0] px1_reg;
    logic [POS_W-1:0] py1_reg;
    logic [PIX_W-1:0] rgb1_reg;
    logic [NUM_W-1:0] numx1_reg;
    logic [NUM_W-1:0] numy1_reg;
    logic             nzx1_reg;
    logic             nzy1_reg;
    logic             inr1_reg;

    always_comb
    begin
        prod_x = NUM_W'({pos_x, 1'b1}) * NUM_W'(m_c);
        prod_y = NUM_W'({pos_y, 1'b1}) * NUM_W'(m_c);
        lhs_x  = (LIM_W'(pos_x) + LIM_W'(1)) * LIM_W'({m_c, 1'b0});
        lhs_y  = (LIM_W'(pos_y) + LIM_W'(1)) * LIM_W'({m_c, 1'b0});
        lim_w  = LIM_W'(DEN) * LIM_W'(w_c) + LIM_W'(m_c);
        lim_h  = LIM_W'(DEN) * LIM_W'(h_c) + LIM_W'(m_c);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            act1_reg  <= action;
            px1_reg   <= pos_x;
            py1_reg   <= pos_y;
            rgb1_reg  <= {red, green, blue};
            numx1_reg <= prod_x - NUM_W'(OUT_SIZE);
            numy1_reg <= prod_y - NUM_W'(OUT_SIZE);
            nzx1_reg  <= prod_x > NUM_W'(OUT_SIZE);
            nzy1_reg  <= prod_y > NUM_W'(OUT_SIZE);
            inr1_reg  <= (lhs_x <= lim_w) && (lhs_y <= lim_h);
        end
    end

    // stage 2: split num*2^FRAC_BITS/2N into an exact product and a reciprocal term
    localparam int PRD_W = NUM_W + 1 + RCP_W;

    logic [PRD_W-1:0] rcp_x;
    logic [PRD_W-1:0] rcp_y;

    logic             act2_reg;
    logic [POS_W-1:0] px2_reg;
    logic [POS_W-1:0] py2_reg;
    logic [PIX_W-1:0] rgb2_reg;
    logic [ACC_W-1:0] ax2_reg;
    logic [ACC_W-1:0] ay2_reg;
    logic [ACC_W-1:0] tx2_reg;
    logic [ACC_W-1:0] ty2_reg;
    logic             nzx2_reg;
    logic             nzy2_reg;
    logic             inr2_reg;

    always_comb
    begin
        rcp_x = PRD_W'({numx1_reg, 1'b0}) * PRD_W'(RCP_MUL);
        rcp_y = PRD_W'({numy1_reg, 1'b0}) * PRD_W'(RCP_MUL);
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            act2_reg <= act1_reg;
            px2_reg  <= px1_reg;
            py2_reg  <= py1_reg;
            rgb2_reg <= rgb1_reg;
            ax2_reg  <= ACC_W'(numx1_reg) * ACC_W'(Q_INT);
            ay2_reg  <= ACC_W'(numy1_reg) * ACC_W'(Q_INT);
            tx2_reg  <= ACC_W'(rcp_x >> RCP_SH);
            ty2_reg  <= ACC_W'(rcp_y >> RCP_SH);
            nzx2_reg <= nzx1_reg;
            nzy2_reg <= nzy1_reg;
            inr2_reg <= inr1_reg;
        end
    end

    // stage 3: neighbours and weights, clamped to the source edges
    localparam int LO_W = ACC_W - FRAC_BITS;

    logic [ACC_W-1:0]     qx;
    logic [ACC_W-1:0]     qy;
    logic [LO_W-1:0]      lox;
    logic [LO_W-1:0]      loy;
    logic [FRAC_BITS-1:0] fx;
    logic [FRAC_BITS-1:0] fy;
    logic [LO_W-1:0]      lastx;
    logic [LO_W-1:0]      lasty;
    logic [LO_W-1:0]      hix;
    logic [LO_W-1:0]      hiy;

    logic                 act3_reg;
    logic [POS_W-1:0]     px3_reg;
    logic [POS_W-1:0]     py3_reg;
    logic [PIX_W-1:0]     rgb3_reg;
    logic [POS_W-1:0]     x0_reg;
    logic [POS_W-1:0]     x1_reg;
    logic [POS_W-1:0]     y0_reg;
    logic [POS_W-1:0]     y1_reg;
    logic [FRAC_BITS-1:0] dx3_reg;
    logic [FRAC_BITS-1:0] dy3_reg;
    logic                 inr3_reg;

    always_comb
    begin
        qx    = ax2_reg + tx2_reg;
        qy    = ay2_reg + ty2_reg;
        lox   = nzx2_reg ? qx[ACC_W-1:FRAC_BITS] : '0;
        loy   = nzy2_reg ? qy[ACC_W-1:FRAC_BITS] : '0;
        fx    = nzx2_reg ? qx[FRAC_BITS-1:0] : '0;
        fy    = nzy2_reg ? qy[FRAC_BITS-1:0] : '0;
        lastx = LO_W'(w_c) - LO_W'(1);
        lasty = LO_W'(h_c) - LO_W'(1);
        if (lox > lastx)
        begin
            lox = lastx;
            fx  = '0;
        end
        if (loy > lasty)
        begin
            loy = lasty;
            fy  = '0;
        end
        hix = (lox < lastx) ? lox + LO_W'(1) : lastx;
        hiy = (loy < lasty) ? loy + LO_W'(1) : lasty;
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            act3_reg <= act2_reg;
            px3_reg  <= px2_reg;
            py3_reg  <= py2_reg;
            rgb3_reg <= rgb2_reg;
            x0_reg   <= lox[POS_W-1:0];
            x1_reg   <= hix[POS_W-1:0];
            y0_reg   <= loy[POS_W-1:0];
            y1_reg   <= hiy[POS_W-1:0];
            dx3_reg  <= fx;
            dy3_reg  <= fy;
            inr3_reg <= inr2_reg;
        end
    end

    // stage 4: parity-banked store, writes and neighbour reads in the same stage
    logic [PIX_W-1:0] rd [BANKS];

    for (genvar b = 0; b < BANKS; b++)
    begin : g_bank
        logic [POS_W-1:0]   col;
        logic [POS_W-1:0]   row;
        logic               we;
        logic [BANK_AW-1:0] waddr;
        logic [BANK_AW-1:0] raddr;

        always_comb
        begin
            col   = (x0_reg[0] == b[0]) ? x0_reg : x1_reg;
            row   = (y0_reg[0] == b[1]) ? y0_reg : y1_reg;
            raddr = {row[POS_W-1:1], col[POS_W-1:1]};
            waddr = {py3_reg[POS_W-1:1], px3_reg[POS_W-1:1]};
            we    = en[4] && vld_reg[3] && (act3_reg == ACT_WRITE)
                    && (px3_reg[0] == b[0]) && (py3_reg[0] == b[1]);
        end

        bres_ram #(
            .WIDTH(PIX_W),
            .DEPTH(BANK_DEPTH)
        ) u_ram (
            .clk  (clk),
            .we   (we),
            .waddr(waddr),
            .wdata(rgb3_reg),
            .re   (en[4]),
            .raddr(raddr),
            .rdata(rd[b])
        );
    end

    logic                 act4_reg;
    logic [1:0]           s00_reg;
    logic [1:0]           s01_reg;
    logic [1:0]           s10_reg;
    logic [1:0]           s11_reg;
    logic [FRAC_BITS-1:0] dx4_reg;
    logic [FRAC_BITS-1:0] dy4_reg;
    logic                 inr4_reg;

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            act4_reg <= act3_reg;
            s00_reg  <= {y0_reg[0], x0_reg[0]};
            s01_reg  <= {y0_reg[0], x1_reg[0]};
            s10_reg  <= {y1_reg[0], x0_reg[0]};
            s11_reg  <= {y1_reg[0], x1_reg[0]};
            dx4_reg  <= dx3_reg;
            dy4_reg  <= dy3_reg;
            inr4_reg <= inr3_reg;
        end
    end

    // stage 5: horizontal blend
    logic [PIX_W-1:0] p00;
    logic [PIX_W-1:0] p01;
    logic [PIX_W-1:0] p10;
    logic [PIX_W-1:0] p11;
    logic [WGT_W-1:0] wx0;
    logic [ROW_W-1:0] r0 [3];
    logic [ROW_W-1:0] r1 [3];

    logic                 act5_reg;
    logic [ROW_W-1:0]     r0_reg [3];
    logic [ROW_W-1:0]     r1_reg [3];
    logic [FRAC_BITS-1:0] dy5_reg;
    logic                 inr5_reg;

    always_comb
    begin
        p00 = rd[s00_reg];
        p01 = rd[s01_reg];
        p10 = rd[s10_reg];
        p11 = rd[s11_reg];
        wx0 = WGT_W'(1 << FRAC_BITS) - WGT_W'(dx4_reg);
        for (int c = 0; c < 3; c++)
        begin
            r0[c] = ROW_W'(ROW_W'(p00[PIX_W-1-CH_W*c -: CH_W]) * ROW_W'(wx0)
                    + ROW_W'(p01[PIX_W-1-CH_W*c -: CH_W]) * ROW_W'(dx4_reg));
            r1[c] = ROW_W'(ROW_W'(p10[PIX_W-1-CH_W*c -: CH_W]) * ROW_W'(wx0)
                    + ROW_W'(p11[PIX_W-1-CH_W*c -: CH_W]) * ROW_W'(dx4_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            act5_reg <= act4_reg;
            r0_reg   <= r0;
            r1_reg   <= r1;
            dy5_reg  <= dy4_reg;
            inr5_reg <= inr4_reg;
        end
    end

    // stage 6: vertical blend, round half up, clamp to a byte
    logic [WGT_W-1:0] wy0;
    logic [SUM_W-1:0] vsum [3];
    logic [SUM_W-1:0] vrnd [3];
    logic [CH_W-1:0]  vbyte [3];

    logic             act6_reg;
    logic [CH_W-1:0]  v6_reg [3];
    logic             inr6_reg;

    always_comb
    begin
        wy0 = WGT_W'(1 << FRAC_BITS) - WGT_W'(dy5_reg);
        for (int c = 0; c < 3; c++)
        begin
            vsum[c] = SUM_W'(r0_reg[c]) * SUM_W'(wy0)
                      + SUM_W'(r1_reg[c]) * SUM_W'(dy5_reg);
            vrnd[c] = (vsum[c] + (SUM_W'(1) << (2 * FRAC_BITS - 1))) >> (2 * FRAC_BITS);
            vbyte[c] = (vrnd[c] > SUM_W'(255)) ? CH_W'(255) : vrnd[c][CH_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            act6_reg <= act5_reg;
            v6_reg   <= vbyte;
            inr6_reg <= inr5_reg;
        end
    end

    // output stage: normalize by table; only requests leave the pipeline
    logic signed [NORM_W-1:0] red_reg;
    logic signed [NORM_W-1:0] green_reg;
    logic signed [NORM_W-1:0] blue_reg;
    logic                     inr_reg;

    always_ff @(posedge clk)
    begin
        if (en_out)
        begin
            red_reg   <= inr6_reg ? NORM_LUT_R[v6_reg[0]] : '0;
            green_reg <= inr6_reg ? NORM_LUT_G[v6_reg[1]] : '0;
            blue_reg  <= inr6_reg ? NORM_LUT_B[v6_reg[2]] : '0;
            inr_reg   <= inr6_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (en[1])
                vld_reg[1] <= req_valid;
            for (int k = 2; k <= 6; k++)
            begin
                if (en[k])
                    vld_reg[k] <= vld_reg[k-1];
            end
            if (en_out)
                out_vld_reg <= vld_reg[6] && (act6_reg == ACT_REQUEST);
        end
    end

    assign res_valid = out_vld_reg;
    assign out_red   = red_reg;
    assign out_green = green_reg;
    assign out_blue  = blue_reg;
    assign in_range  = inr_reg;

    a_zero_outside: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !in_range |-> out_red == '0 && out_green == '0 && out_blue == '0)
        else $error("out-of-range result carries nonzero channels");

    a_neighbour_order: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[3] && act3_reg == ACT_REQUEST |-> x1_reg >= x0_reg && y1_reg >= y0_reg
            && x1_reg - x0_reg <= POS_W'(1) && y1_reg - y0_reg <= POS_W'(1))
        else $error("neighbour pair out of order");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> vld_reg[1] && !en[2])
        else $error("request side stalled with a free first stage");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(out_red) && $stable(in_range))
        else $error("pending result changed while stalled");

endmodule
